FILE: sv/rmh_pkg.sv
// Package for the running median block: heap command codes, median select codes
// and the command and status bundles between the controller and the datapath.
// No dependencies.
`timescale 1ns / 1ps
package rmh_pkg;

   localparam int HALF_DEPTH_DEF  = 512;
   localparam int SAMPLE_BITS_DEF = 16;
   localparam int SAMPLE_W        = 16;
   localparam int MEDIAN_W        = 16;
   localparam int COUNT_W         = 11;
   localparam int TDATA_IN_W      = 16;
   localparam int TDATA_OUT_W     = 32;

   typedef enum logic [1:0] {
      HOP_NONE,
      HOP_PUSH,
      HOP_REPLACE,
      HOP_CLEAR
   } heap_op_type;

   typedef enum logic [2:0] {
      MED_KEEP,
      MED_X,
      MED_LO,
      MED_UP,
      MED_MEAN
   } med_sel_type;

   typedef struct packed {
      logic        accept;
      heap_op_type lo_op;
      heap_op_type up_op;
      logic        lo_other;
      logic        up_other;
      logic        finish;
      med_sel_type med_sel;
      logic        full;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic lo_gt;
      logic eq;
      logic x_lt_med;
      logic x_gt_med;
      logic busy;
      logic balanced;
   } stat_type;

endpackage

FILE: sv/rmh_heap.sv
// One heap held in a memory, with a sift engine for push and root replacement.
// Depends on rmh_pkg.
`timescale 1ns / 1ps
module rmh_heap #(
   parameter int HALF_DEPTH  = 512,
   parameter int SAMPLE_BITS = 16,
   parameter bit IS_MAX      = 1'b1
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  rmh_pkg::heap_op_type                   op,
   input  logic [SAMPLE_BITS-1:0]                 op_val,
   output logic                                   busy,
   output logic [SAMPLE_BITS-1:0]                 top,
   output logic [$clog2(HALF_DEPTH+1)-1:0]        size
);
   import rmh_pkg::*;

   localparam int AW = $clog2(HALF_DEPTH);
   localparam int SW = $clog2(HALF_DEPTH + 1);

   typedef enum logic [2:0] {
      H_IDLE,
      H_UP_CHK,
      H_UP_CMP,
      H_DN_CHK,
      H_DN_CMP
   } hstate_type;

   hstate_type             state_ff, state_in;
   logic [AW-1:0]          idx_ff, idx_in;
   logic [SAMPLE_BITS-1:0] val_ff, val_in;
   logic [SW-1:0]          size_ff, size_in;
   logic [SAMPLE_BITS-1:0] top_ff, top_in;

   logic [SAMPLE_BITS-1:0] mem [HALF_DEPTH];
   logic [SAMPLE_BITS-1:0] rda_ff, rdb_ff;
   logic                   we;
   logic [AW-1:0]          wa, ra, rb;
   logic [SAMPLE_BITS-1:0] wd;

   logic [AW-1:0]          parent;
   logic [SW:0]            l_pos, r_pos, n_ext;
   logic                   take_l, take_r;
   logic [SAMPLE_BITS-1:0] best_l;

   function automatic logic ranks(input logic [SAMPLE_BITS-1:0] a,
                                  input logic [SAMPLE_BITS-1:0] b);
      return IS_MAX ? (a > b) : (a < b);
   endfunction

   assign parent = (idx_ff - 1'b1) >> 1;
   assign l_pos  = (SW+1)'({idx_ff, 1'b1});
   assign r_pos  = l_pos + 1'b1;
   assign n_ext  = (SW+1)'(size_ff);
   assign take_l = ranks(rda_ff, val_ff);
   assign best_l = take_l ? rda_ff : val_ff;
   assign take_r = (r_pos < n_ext) && ranks(rdb_ff, best_l);

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      val_in   = val_ff;
      size_in  = size_ff;
      we       = 1'b0;
      wa       = idx_ff;
      wd       = val_ff;
      ra       = parent;
      rb       = AW'(r_pos);
      unique case (state_ff)
         H_IDLE: begin
            case (op)
               HOP_PUSH: begin
                  size_in  = size_ff + 1'b1;
                  idx_in   = AW'(size_ff);
                  val_in   = op_val;
                  state_in = H_UP_CHK;
               end
               HOP_REPLACE: begin
                  idx_in   = '0;
                  val_in   = op_val;
                  state_in = H_DN_CHK;
               end
               HOP_CLEAR: begin
                  size_in = '0;
               end
               default: begin
               end
            endcase
         end
         H_UP_CHK: begin
            if (idx_ff == '0) begin
               we       = 1'b1;
               state_in = H_IDLE;
            end else begin
               state_in = H_UP_CMP;
            end
         end
         H_UP_CMP: begin
            we = 1'b1;
            if (ranks(val_ff, rda_ff)) begin
               wd       = rda_ff;
               idx_in   = parent;
               state_in = H_UP_CHK;
            end else begin
               state_in = H_IDLE;
            end
         end
         H_DN_CHK: begin
            ra = AW'(l_pos);
            if (l_pos >= n_ext) begin
               we       = 1'b1;
               state_in = H_IDLE;
            end else begin
               state_in = H_DN_CMP;
            end
         end
         H_DN_CMP: begin
            we = 1'b1;
            if (take_r) begin
               wd       = rdb_ff;
               idx_in   = AW'(r_pos);
               state_in = H_DN_CHK;
            end else if (take_l) begin
               wd       = rda_ff;
               idx_in   = AW'(l_pos);
               state_in = H_DN_CHK;
            end else begin
               state_in = H_IDLE;
            end
         end
         default: state_in = H_IDLE;
      endcase
      top_in = (we && wa == '0) ? wd : top_ff;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      rda_ff <= mem[ra];
      rdb_ff <= mem[rb];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= H_IDLE;
         size_ff  <= '0;
      end else begin
         state_ff <= state_in;
         size_ff  <= size_in;
      end
      idx_ff <= idx_in;
      val_ff <= val_in;
      top_ff <= top_in;
   end

   assign busy = (state_ff != H_IDLE);
   assign top  = top_ff;
   assign size = size_ff;

endmodule

FILE: sv/rmh_dp.sv
// Datapath of the running median block: sample and median registers, the two
// heaps and the result register. Depends on rmh_pkg and rmh_heap.
`timescale 1ns / 1ps
module rmh_dp #(
   parameter int HALF_DEPTH  = 512,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  rmh_pkg::cmd_type                cmd,
   input  logic [rmh_pkg::SAMPLE_W-1:0]    in_sample,
   input  logic                            in_restart,
   output rmh_pkg::stat_type               stat,
   output logic [rmh_pkg::MEDIAN_W-1:0]    out_median,
   output logic                            out_full,
   output logic [rmh_pkg::COUNT_W-1:0]     out_count
);
   import rmh_pkg::*;

   localparam int SW = $clog2(HALF_DEPTH + 1);

   logic [SAMPLE_BITS-1:0] x_ff;
   logic [SAMPLE_BITS-1:0] med_ff, med_in;
   logic [MEDIAN_W-1:0]    rsp_median_ff;
   logic                   rsp_full_ff;
   logic [COUNT_W-1:0]     rsp_count_ff;

   heap_op_type            lo_op, up_op;
   logic [SAMPLE_BITS-1:0] lo_val, up_val, lo_top, up_top;
   logic                   lo_busy, up_busy;
   logic [SW-1:0]          lo_size, up_size;
   logic [SW:0]            total;
   logic [SAMPLE_BITS:0]   tops_sum;

   assign lo_op  = (cmd.accept && in_restart) ? HOP_CLEAR : cmd.lo_op;
   assign up_op  = (cmd.accept && in_restart) ? HOP_CLEAR : cmd.up_op;
   assign lo_val = cmd.lo_other ? up_top : x_ff;
   assign up_val = cmd.up_other ? lo_top : x_ff;

   rmh_heap #(.HALF_DEPTH(HALF_DEPTH), .SAMPLE_BITS(SAMPLE_BITS), .IS_MAX(1'b1)) u_lo (
      .clock (clock),
      .reset (reset),
      .op    (lo_op),
      .op_val(lo_val),
      .busy  (lo_busy),
      .top   (lo_top),
      .size  (lo_size)
   );

   rmh_heap #(.HALF_DEPTH(HALF_DEPTH), .SAMPLE_BITS(SAMPLE_BITS), .IS_MAX(1'b0)) u_up (
      .clock (clock),
      .reset (reset),
      .op    (up_op),
      .op_val(up_val),
      .busy  (up_busy),
      .top   (up_top),
      .size  (up_size)
   );

   assign total    = (SW+1)'(lo_size) + (SW+1)'(up_size);
   assign tops_sum = (SAMPLE_BITS+1)'(lo_top) + (SAMPLE_BITS+1)'(up_top);

   always_comb begin
      case (cmd.med_sel)
         MED_X:    med_in = x_ff;
         MED_LO:   med_in = lo_top;
         MED_UP:   med_in = up_top;
         MED_MEAN: med_in = SAMPLE_BITS'(tops_sum >> 1);
         default:  med_in = med_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         med_ff <= '0;
      end else if (cmd.accept && in_restart) begin
         med_ff <= '0;
      end else if (cmd.finish) begin
         med_ff <= med_in;
      end
      if (cmd.accept) begin
         x_ff <= SAMPLE_BITS'(in_sample);
      end
      if (cmd.finish) begin
         rsp_median_ff <= MEDIAN_W'(med_in);
         rsp_full_ff   <= cmd.full;
         rsp_count_ff  <= COUNT_W'(total);
      end
   end

   assign stat.full     = (total >= (SW+1)'(2 * HALF_DEPTH));
   assign stat.empty    = (total == '0);
   assign stat.lo_gt    = (lo_size > up_size);
   assign stat.eq       = (lo_size == up_size);
   assign stat.x_lt_med = (x_ff < med_ff);
   assign stat.x_gt_med = (x_ff > med_ff);
   assign stat.busy     = lo_busy || up_busy;
   assign stat.balanced = ((SW+1)'(lo_size) <= (SW+1)'(up_size) + 1'b1) &&
                          ((SW+1)'(up_size) <= (SW+1)'(lo_size) + 1'b1);

   assign out_median = rsp_median_ff;
   assign out_full   = rsp_full_ff;
   assign out_count  = rsp_count_ff;

endmodule

FILE: sv/rmh_ctrl.sv
// Controller of the running median block: takes a word, picks the heap
// operations and the median source, and hands the result word out. Uses rmh_pkg.
`timescale 1ns / 1ps
module rmh_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  rmh_pkg::stat_type stat,
   output rmh_pkg::cmd_type  cmd
);
   import rmh_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_DECIDE,
      S_WAIT,
      S_FINISH
   } state_type;

   state_type   state_ff;
   med_sel_type med_sel_ff;
   logic        full_ff;
   logic        rsp_valid_ff;
   logic        out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      cmd.lo_op    = HOP_NONE;
      cmd.up_op    = HOP_NONE;
      cmd.med_sel  = MED_KEEP;
      unique case (state_ff)
         S_IDLE: cmd.accept = req_valid;
         S_DECIDE: begin
            if (stat.full) begin
               cmd.full = 1'b1;
            end else if (stat.empty) begin
               cmd.lo_op   = HOP_PUSH;
               cmd.med_sel = MED_X;
            end else if (stat.lo_gt) begin
               cmd.med_sel = MED_MEAN;
               cmd.up_op   = HOP_PUSH;
               if (stat.x_lt_med) begin
                  cmd.up_other = 1'b1;
                  cmd.lo_op    = HOP_REPLACE;
               end
            end else if (stat.eq) begin
               if (stat.x_lt_med) begin
                  cmd.lo_op   = HOP_PUSH;
                  cmd.med_sel = MED_LO;
               end else begin
                  cmd.up_op   = HOP_PUSH;
                  cmd.med_sel = MED_UP;
               end
            end else begin
               cmd.med_sel = MED_MEAN;
               cmd.lo_op   = HOP_PUSH;
               if (stat.x_gt_med) begin
                  cmd.lo_other = 1'b1;
                  cmd.up_op    = HOP_REPLACE;
               end
            end
         end
         S_WAIT: begin
         end
         S_FINISH: begin
            cmd.finish  = out_free;
            cmd.med_sel = med_sel_ff;
            cmd.full    = full_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         med_sel_ff   <= MED_KEEP;
         full_ff      <= 1'b0;
      end else begin
         if (state_ff == S_FINISH && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= S_DECIDE;
               end
            end
            S_DECIDE: begin
               med_sel_ff <= cmd.med_sel;
               full_ff    <= cmd.full;
               state_ff   <= S_WAIT;
            end
            S_WAIT: begin
               if (!stat.busy) begin
                  state_ff <= S_FINISH;
               end
            end
            S_FINISH: begin
               if (out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

FILE: sv/running_median_two_heaps.sv
// Running median over two heaps: a result is registered after the heap sift for its word is done,
// and a new word is taken only after the last word's result is registered, held back by the
// heap sift (each level a read step, then a compare and write step).
// The result register lets a new word be taken while the last result waits.
// Synchronous active-high reset empties both heaps and clears the median.
// Depends on rmh_pkg, rmh_ctrl and rmh_dp.
`timescale 1ns / 1ps
module running_median_two_heaps #(
   parameter int HALF_DEPTH  = rmh_pkg::HALF_DEPTH_DEF,
   parameter int SAMPLE_BITS = rmh_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // Bits 15:0 sample.
   input  logic [rmh_pkg::TDATA_IN_W-1:0]      req_tdata,
   // Bit 0 restart.
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // Bits 15:0 median, bits 26:16 count, bits 31:27 zero.
   output logic [rmh_pkg::TDATA_OUT_W-1:0]     rsp_tdata,
   // Bit 0 full_res.
   output logic                                rsp_tuser
);
   import rmh_pkg::*;

   cmd_type             dp_cmd;
   stat_type            dp_stat;
   logic [MEDIAN_W-1:0] median;
   logic [COUNT_W-1:0]  count;

   rmh_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_tvalid),
      .req_ready(req_tready),
      .rsp_valid(rsp_tvalid),
      .rsp_ready(rsp_tready),
      .stat     (dp_stat),
      .cmd      (dp_cmd)
   );

   rmh_dp #(.HALF_DEPTH(HALF_DEPTH), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (dp_cmd),
      .in_sample (req_tdata[SAMPLE_W-1:0]),
      .in_restart(req_tuser),
      .stat      (dp_stat),
      .out_median(median),
      .out_full  (rsp_tuser),
      .out_count (count)
   );

   assign rsp_tdata = {(TDATA_OUT_W - MEDIAN_W - COUNT_W)'(0), count, median};

   a_balanced: assert property (@(posedge clock) disable iff (reset)
      dp_stat.balanced)
      else $error("heap sizes differ by more than one");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> count == COUNT_W'(2 * HALF_DEPTH))
      else $error("full result without full storage");

   a_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (2 * HALF_DEPTH < 2 ** COUNT_W) |-> count != '0)
      else $error("result reports an empty set");

endmodule
